// ----- hdl/tssf_pkg.sv -----
// shared types and constants for the triangle span fill unit
`default_nettype none
package tssf_pkg;
    localparam int ROWS_DEF       = 32;
    localparam int COORD_BITS_DEF = 12;
    localparam int ROW_BITS       = 6;
    // classified flat job: pair p/q on py, apex r, from the front to the back
    // split: px is the low end of the long edge, oy its y; reuse keeps the split x
    localparam int CW = 16;
    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] oy;
        logic                 split;
        logic                 reuse;
        logic                 last_job;
    } job_t;
endpackage
`default_nettype wire

// ----- hdl/tssf_div.sv -----
// sequential signed divider, truncating toward zero, one quotient bit a cycle
`default_nettype none
module tssf_div #(
    parameter int NW = 34,
    parameter int DW = 18
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire signed [NW-1:0]  num,
    input  wire signed [DW-1:0]  den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CB = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next, busy_reg, busy_next, done_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;

    // restoring step
    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        busy_next = busy_reg; cnt_next = cnt_reg; done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = num[NW-1] ? NW'(-num) : num;
            d_next = den[DW-1] ? DW'(-den) : den;
            neg_next = num[NW-1] ^ den[DW-1];
            r_next = '0;
            busy_next = 1'b1;
            cnt_next = CB'(NW);
        end
        else if (busy_reg)
        begin
            trial = {r_reg[DW-1:0], q_reg[NW-1]} - {1'b0, d_reg};
            if (!trial[DW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end

    assign quo = (d_reg == '0) ? '0 : (neg_reg ? NW'(-q_reg) : q_reg);
endmodule
`default_nettype wire

// ----- hdl/tssf_front.sv -----
// front: accepts a triangle, classifies it and queues up to two flat jobs
`default_nettype none
module tssf_front #(
    parameter int ROWS       = tssf_pkg::ROWS_DEF,
    parameter int COORD_BITS = tssf_pkg::COORD_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         valid,
    output logic                        ready,
    input  wire signed [COORD_BITS-1:0] a_x,
    input  wire signed [COORD_BITS-1:0] a_y,
    input  wire signed [COORD_BITS-1:0] b_x,
    input  wire signed [COORD_BITS-1:0] b_y,
    input  wire signed [COORD_BITS-1:0] c_x,
    input  wire signed [COORD_BITS-1:0] c_y,
    output logic                        job_valid,
    input  wire                         job_ready,
    output tssf_pkg::job_t              job
);
    localparam int CW = tssf_pkg::CW;
    // two-entry queue of flat jobs
    tssf_pkg::job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, fx, fy, mx, my, lx, ly;
    tssf_pkg::job_t j0, j1;
    logic two, none, low_empty;

    assign ax = CW'(a_x); assign ay = CW'(a_y);
    assign bx = CW'(b_x); assign by = CW'(b_y);
    assign cx = CW'(c_x); assign cy = CW'(c_y);

    // vertex ordering and flat detection
    always_comb
    begin
        fx = cx; fy = cy; mx = bx; my = by; lx = ax; ly = ay;
        if (by < ay)
        begin
            if (cy < by)
            begin
                fx = ax; fy = ay; mx = bx; my = by; lx = cx; ly = cy;
            end
            else if (cy < ay)
            begin
                fx = ax; fy = ay; mx = cx; my = cy; lx = bx; ly = by;
            end
            else
            begin
                fx = cx; fy = cy; mx = ax; my = ay; lx = bx; ly = by;
            end
        end
        else
        begin
            if (cy < ay)
            begin
                fx = bx; fy = by; mx = ax; my = ay; lx = cx; ly = cy;
            end
            else if (cy < by)
            begin
                fx = bx; fy = by; mx = cx; my = cy; lx = ax; ly = ay;
            end
        end
        none = 1'b0; two = 1'b0; low_empty = 1'b0;
        j0 = '0; j1 = '0;
        if (ay == by)
        begin
            none = (ay == cy);
            j0 = '{px: ax, py: ay, qx: bx, rx: cx, ry: cy, oy: cy,
                   split: 1'b0, reuse: 1'b0, last_job: 1'b1};
        end
        else if (ay == cy)
            j0 = '{px: ax, py: ay, qx: cx, rx: bx, ry: by, oy: by,
                   split: 1'b0, reuse: 1'b0, last_job: 1'b1};
        else if (by == cy)
            j0 = '{px: bx, py: by, qx: cx, rx: ax, ry: ay, oy: ay,
                   split: 1'b0, reuse: 1'b0, last_job: 1'b1};
        else
        begin
            // split x is computed by the back part from the long edge
            // lower half off screen: the upper half carries the last span
            two = 1'b1;
            low_empty = my[CW-1] || (ly > CW'(ROWS - 1));
            j0 = '{px: lx, py: my, qx: mx, rx: fx, ry: fy, oy: ly,
                   split: 1'b1, reuse: 1'b0, last_job: low_empty};
            j1 = '{px: lx, py: my, qx: mx, rx: lx, ry: ly, oy: ly,
                   split: 1'b0, reuse: 1'b1, last_job: 1'b1};
        end
    end

    assign ready = (cnt_reg == 2'd0);
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[0];

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (valid && ready)
            cnt_reg <= none ? 2'd0 : (two ? 2'd2 : 2'd1);
        else if (job_valid && job_ready)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            q_reg[0] <= j0;
            q_reg[1] <= j1;
        end
        else if (job_valid && job_ready)
            q_reg[0] <= q_reg[1];
    end
endmodule
`default_nettype wire

// ----- hdl/tssf_back.sv -----
// back: walks the rows of each flat job with a shared divider
`default_nettype none
module tssf_back #(
    parameter int ROWS       = tssf_pkg::ROWS_DEF,
    parameter int COORD_BITS = tssf_pkg::COORD_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          job_valid,
    output logic                         job_ready,
    input  tssf_pkg::job_t               job,
    output logic                         valid,
    input  wire                          ready,
    output logic signed [COORD_BITS-1:0] span_start_x,
    output logic signed [COORD_BITS-1:0] span_end_x,
    output logic [tssf_pkg::ROW_BITS-1:0] span_row,
    output logic                         last_span
);
    localparam int CW = tssf_pkg::CW;
    localparam int NW = 2 * CW + 2;
    localparam int DW = CW + 2;
    localparam logic [3:0] S_IDLE = 4'd0, S_SPL = 4'd1, S_SPLW = 4'd2,
        S_ROW = 4'd3, S_DA = 4'd4, S_WA = 4'd5, S_DB = 4'd6, S_WB = 4'd7,
        S_OUT = 4'd8;
    logic [3:0] st_reg, st_next;
    tssf_pkg::job_t j_reg;
    logic signed [CW-1:0] sx_reg, y_reg, hi_reg, xa_reg;
    logic signed [CW+1:0] dy, dxp, dxq, ty, sdx, sdy, sty;
    logic signed [NW-1:0] prod_reg, num;
    logic signed [DW-1:0] den;
    logic div_start, div_done;
    logic signed [NW-1:0] quo;
    logic signed [CW-1:0] lo, hi;
    logic done_job;

    tssf_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(den),
        .done(div_done), .quo(quo)
    );

    assign dy  = (CW+2)'(j_reg.ry) - (CW+2)'(j_reg.py);
    assign dxp = (CW+2)'(j_reg.rx) - (CW+2)'(sx_reg);
    assign dxq = (CW+2)'(j_reg.rx) - (CW+2)'(j_reg.qx);
    assign ty  = (CW+2)'(y_reg) - (CW+2)'(j_reg.py);
    // split x: px + (py-oy)*(rx-px)/(ry-oy) on the long edge
    assign sty = (CW+2)'(job.py) - (CW+2)'(job.oy);
    assign sdx = (CW+2)'(job.rx) - (CW+2)'(job.px);
    assign sdy = (CW+2)'(j_reg.ry) - (CW+2)'(j_reg.oy);
    assign num = prod_reg;
    assign den = (st_reg == S_SPL) ? DW'(sdy) : DW'(dy);

    // clipped row range of a new job
    always_comb
    begin
        lo = (job.py < job.ry) ? job.py : job.ry;
        hi = (job.py < job.ry) ? job.ry : job.py;
        if (hi > CW'(ROWS - 1)) hi = CW'(ROWS - 1);
        if (lo < 0) lo = '0;
    end

    assign job_ready = (st_reg == S_IDLE);
    assign valid = (st_reg == S_OUT);
    assign done_job = (y_reg >= hi_reg);
    assign div_start = (st_reg == S_SPL) || (st_reg == S_DA) || (st_reg == S_DB);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (job_valid) st_next = job.split ? S_SPL : S_ROW;
            S_SPL:  st_next = S_SPLW;
            S_SPLW: if (div_done) st_next = S_ROW;
            S_ROW:  st_next = (y_reg > hi_reg) ? S_IDLE : S_DA;
            S_DA:   st_next = S_WA;
            S_WA:   if (div_done) st_next = S_DB;
            S_DB:   st_next = S_WB;
            S_WB:   if (div_done) st_next = S_OUT;
            S_OUT:  if (ready) st_next = done_job ? S_IDLE : S_ROW;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    // datapath; the second half of a split keeps the split x
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            if (job_valid)
            begin
                j_reg <= job; y_reg <= lo; hi_reg <= hi;
                if (!job.reuse)
                    sx_reg <= job.px;
                if (job.split)
                    prod_reg <= NW'(sty) * NW'(sdx);
            end
            S_SPLW: if (div_done) sx_reg <= CW'(NW'(j_reg.px) + quo);
            S_ROW: prod_reg <= NW'(ty) * NW'(dxp);
            S_WA:
            if (div_done)
            begin
                xa_reg <= CW'(NW'(sx_reg) + quo);
                prod_reg <= NW'(ty) * NW'(dxq);
            end
            S_WB: if (div_done) span_end_x <= COORD_BITS'(NW'(j_reg.qx) + quo);
            S_OUT: if (ready) y_reg <= y_reg + 1'b1;
            default: ;
        endcase
    end

    assign span_start_x = COORD_BITS'(xa_reg);
    assign span_row = tssf_pkg::ROW_BITS'(y_reg);
    assign last_span = j_reg.last_job && done_job;
endmodule
`default_nettype wire

// ----- hdl/triangle_scanline_span_fill_unit.sv -----
// top level of the triangle scanline span fill unit
//  channel | direction | payload
//  input   | in        | a_x a_y b_x b_y c_x c_y
//  span    | out       | span_start_x span_end_x span_row last_span
// each span, when not stalled, takes two serial divisions of 34 restoring steps
// each; a split triangle adds one more division for its split x; up to ROWS+1
// spans a triangle.
// reset clears the queue and the row sequencer; a stalled span holds.
// a new triangle is taken once the job queue is empty.
`default_nettype none
module triangle_scanline_span_fill_unit #(
    parameter int ROWS       = tssf_pkg::ROWS_DEF,
    parameter int COORD_BITS = tssf_pkg::COORD_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire signed [COORD_BITS-1:0]  a_x,
    input  wire signed [COORD_BITS-1:0]  a_y,
    input  wire signed [COORD_BITS-1:0]  b_x,
    input  wire signed [COORD_BITS-1:0]  b_y,
    input  wire signed [COORD_BITS-1:0]  c_x,
    input  wire signed [COORD_BITS-1:0]  c_y,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [COORD_BITS-1:0] span_start_x,
    output logic signed [COORD_BITS-1:0] span_end_x,
    output logic [5:0]                   span_row,
    output logic                         last_span
);
    logic jv, jr;
    tssf_pkg::job_t jb;

    tssf_front #(.ROWS(ROWS), .COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .c_x(c_x), .c_y(c_y),
        .job_valid(jv), .job_ready(jr), .job(jb)
    );

    tssf_back #(.ROWS(ROWS), .COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
        .valid(out_valid), .ready(out_ready), .span_start_x(span_start_x),
        .span_end_x(span_end_x), .span_row(span_row), .last_span(last_span)
    );

    // spans stay on screen
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (span_row < 6'(ROWS))) else $error("row out of range");
    // a stalled span keeps its row
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(span_row)) else $error("span moved");
endmodule
`default_nettype wire

// ----- dv/tssf_span_checker.sv -----
// span checker: predicts the fill spans of each accepted triangle and compares them
module tssf_span_checker #(
    parameter int ROWS       = 32,
    parameter int COORD_BITS = 12
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    input  wire                         in_ready,
    input  wire signed [COORD_BITS-1:0] a_x,
    input  wire signed [COORD_BITS-1:0] a_y,
    input  wire signed [COORD_BITS-1:0] b_x,
    input  wire signed [COORD_BITS-1:0] b_y,
    input  wire signed [COORD_BITS-1:0] c_x,
    input  wire signed [COORD_BITS-1:0] c_y,
    input  wire                         out_valid,
    input  wire                         out_ready,
    input  wire signed [COORD_BITS-1:0] span_start_x,
    input  wire signed [COORD_BITS-1:0] span_end_x,
    input  wire [5:0]                   span_row,
    input  wire                         last_span,
    output int                          fail_count,
    output int                          spans_waiting,
    output int                          spans_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SPANS = 64;

    typedef struct {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] ex;
        logic [5:0]            row;
        logic                  last;
    } span_t;

    span_t span_q[$];
    int    tri_spans;

    // walk one flat triangle bottom-up over the visible rows
    task automatic fill_flat(input longint px, input longint py, input longint qx,
                             input longint rx, input longint ry);
        longint lo, hi, y, xa, xb, dy;
        span_t  s;
        dy = ry - py;
        lo = (py < ry) ? py : ry;
        hi = (py < ry) ? ry : py;
        if (hi > ROWS - 1) hi = ROWS - 1;
        if (lo < 0) lo = 0;
        for (y = lo; y <= hi; y++)
        begin
            if (tri_spans >= MAX_SPANS) break;
            xa = px + ((dy == 0) ? 0 : ((y - py) * (rx - px)) / dy);
            xb = qx + ((dy == 0) ? 0 : ((y - py) * (rx - qx)) / dy);
            s.sx   = xa[COORD_BITS-1:0];
            s.ex   = xb[COORD_BITS-1:0];
            s.row  = y[5:0];
            s.last = 1'b0;
            span_q.push_back(s);
            tri_spans++;
        end
    endtask

    // split on the long edge at the middle height, then fill both halves
    task automatic split_fill(input longint fx, input longint fy, input longint mx,
                              input longint my, input longint lx, input longint ly);
        longint sx;
        sx = lx + ((my - ly) * (fx - lx)) / (fy - ly);
        fill_flat(sx, my, mx, fx, fy);
        fill_flat(sx, my, mx, lx, ly);
    endtask

    task automatic predict_spans(input longint ax, input longint ay, input longint bx,
                                 input longint by, input longint cx, input longint cy);
        tri_spans = 0;
        if (ay == by)
        begin
            if (ay != cy) fill_flat(ax, ay, bx, cx, cy);
        end
        else if (ay == cy) fill_flat(ax, ay, cx, bx, by);
        else if (by == cy) fill_flat(bx, by, cx, ax, ay);
        else if (by < ay)
        begin
            if (cy < by)      split_fill(ax, ay, bx, by, cx, cy);
            else if (cy < ay) split_fill(ax, ay, cx, cy, bx, by);
            else              split_fill(cx, cy, ax, ay, bx, by);
        end
        else
        begin
            if (cy < ay)      split_fill(bx, by, ax, ay, cx, cy);
            else if (cy < by) split_fill(bx, by, cx, cy, ax, ay);
            else              split_fill(cx, cy, bx, by, ax, ay);
        end
        if (tri_spans > 0) span_q[span_q.size()-1].last = 1'b1;
    endtask

    // watch both channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        span_t e;
        if (!rst_n)
        begin
            span_q.delete();
            fail_count    = 0;
            spans_waiting = 0;
            spans_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_spans(a_x, a_y, b_x, b_y, c_x, c_y);
            if (out_valid && out_ready)
            begin
                spans_checked++;
                if (span_q.size() == 0)
                begin
                    $error("unexpected span row %0d", span_row);
                    fail_count++;
                end
                else
                begin
                    e = span_q.pop_front();
                    if (span_start_x !== e.sx)
                    begin
                        $error("span_start_x expected %0d got %0d",
                               $signed(e.sx), span_start_x);
                        fail_count++;
                    end
                    if (span_end_x !== e.ex)
                    begin
                        $error("span_end_x expected %0d got %0d", $signed(e.ex), span_end_x);
                        fail_count++;
                    end
                    if (span_row !== e.row)
                    begin
                        $error("span_row expected %0d got %0d", e.row, span_row);
                        fail_count++;
                    end
                    if (last_span !== e.last)
                    begin
                        $error("last_span expected %0d got %0d", e.last, last_span);
                        fail_count++;
                    end
                end
            end
            spans_waiting = span_q.size();
        end
    end
endmodule

// ----- dv/tb.sv -----
// testbench top: triangle stimulus, output back-pressure and the verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CB    = 12;
    localparam longint LIMIT = 6000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [CB-1:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [CB-1:0] span_start_x, span_end_x;
    logic [5:0]           span_row;
    logic                 last_span;

    int     fail_count, spans_waiting, spans_checked;
    int     send_idle_pct = 0, recv_idle_pct = 0, hold_left = 0;
    int     tris_sent = 0;
    longint cycles = 0;

    triangle_scanline_span_fill_unit DUT (.*);

    tssf_span_checker #(.ROWS(32), .COORD_BITS(CB)) u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: random idling plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one triangle request and wait until it is taken
    task automatic send_tri(input int ax, input int ay, input int bx,
                            input int by, input int cx, input int cy);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        a_x = CB'(ax); a_y = CB'(ay); b_x = CB'(bx);
        b_y = CB'(by); c_x = CB'(cx); c_y = CB'(cy);
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tris_sent++;
    endtask

    task automatic drain_spans();
        @(negedge clk);
        in_valid = 1'b0;
        while (spans_waiting != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    function automatic int rand_x();
        if ($urandom_range(3) == 0) return $signed(12'($urandom));
        return $urandom_range(200) - 100;
    endfunction

    function automatic int rand_y();
        int r;
        r = $urandom_range(19);
        if (r == 0) return $signed(12'($urandom));
        if (r == 1) return $urandom_range(3) ? -2048 : 2047;
        return $urandom_range(47) - 8;
    endfunction

    // random triangle, often with a flat edge or fully degenerate
    task automatic send_random();
        int ax, ay, bx, by, cx, cy;
        ax = rand_x(); bx = rand_x(); cx = rand_x();
        ay = rand_y(); by = rand_y(); cy = rand_y();
        case ($urandom_range(9))
            0: by = ay;
            1: cy = ay;
            2: cy = by;
            3: if ($urandom_range(3) == 0) begin by = ay; cy = ay; end
            default: ;
        endcase
        send_tri(ax, ay, bx, by, cx, cy);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: degenerate, each flat pairing, every ordering, clipping, extremes
        send_idle_pct = 11; recv_idle_pct = 56;
        send_tri(5, 7, 20, 7, -3, 7);
        send_tri(0, 2, 30, 2, 15, 20);
        send_tri(0, 25, 10, 3, 30, 25);
        send_tri(-5, 10, 8, 0, 40, 0);
        send_tri(10, 20, 0, 10, 30, 2);
        send_tri(10, 20, 0, 2, 30, 10);
        send_tri(10, 2, 0, 20, 30, 10);
        send_tri(10, 10, 0, 20, 30, 2);
        send_tri(10, 2, 0, 10, 30, 20);
        send_tri(10, 10, 0, 2, 30, 20);
        send_tri(-2048, -2048, 2047, 2047, 0, 0);
        send_tri(2047, -2048, -2048, 2047, 2047, 2047);
        send_tri(-2048, -50, 2047, -60, 0, -100);
        send_tri(100, 40, -100, 50, 0, 2047);
        send_tri(-1, -1, 1, 31, 0, 32);
        send_tri(7, 0, 7, 31, 7, 15);
        send_tri(-2048, 31, 2047, 31, 1, -2048);
        send_tri(-1365, 15, 1365, 16, -1, 17);
        send_tri(0, -2048, 0, 2047, 0, -2048);

        // sender keeps offering while the receiver holds off
        hold_left = 4000;
        repeat (4) send_random();
        drain_spans();

        repeat (100) send_random();
        drain_spans();
        send_idle_pct = 56; recv_idle_pct = 11;
        repeat (110) send_random();
        drain_spans();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (110) send_random();
        drain_spans();

        $display("tb: %0d triangles sent, %0d spans checked", tris_sent, spans_checked);
        $display("tb: flat, split, degenerate, clipped and extreme vertices under stalls");
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
